>>> src/mfb_pkg.sv
`default_nettype none

package mfb_pkg;

    // Store size in bytes; the largest geometry needs 12000
    localparam int STORE_BYTES = 16384;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int CNT_W       = ADDR_W + 1;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Geometry per profile
    localparam logic [8:0] WIDTH_P0  = 9'd320;
    localparam logic [7:0] HEIGHT_P0 = 8'd170;
    localparam logic [8:0] WIDTH_P1  = 9'd400;
    localparam logic [7:0] HEIGHT_P1 = 8'd240;
    localparam logic [5:0] STRIDE_P0 = 6'((320 + 7) / 8);
    localparam logic [5:0] STRIDE_P1 = 6'((400 + 7) / 8);

    localparam int USED_P0 = ((320 + 7) / 8) * 170;
    localparam int USED_P1 = ((400 + 7) / 8) * 240;
    localparam int FILL_P0 = (USED_P0 < STORE_BYTES) ? USED_P0 : STORE_BYTES;
    localparam int FILL_P1 = (USED_P1 < STORE_BYTES) ? USED_P1 : STORE_BYTES;

    // Last byte index of each sweep
    localparam logic [CNT_W-1:0] LAST_P0   = CNT_W'(FILL_P0 - 1);
    localparam logic [CNT_W-1:0] LAST_P1   = CNT_W'(FILL_P1 - 1);
    localparam logic [CNT_W-1:0] LAST_INIT = CNT_W'(STORE_BYTES - 1);

    localparam logic [7:0] MASK_MSB = 8'h80;
    localparam logic [7:0] FILL_ONE = 8'hFF;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               ink_black;
    } t_in_item;

    typedef struct packed {
        logic in_bounds;
        logic pixel_value;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RMW,
        ST_RESP
    } t_state;

endpackage

`default_nettype wire

>>> src/mono_framebuffer_pixel_store.sv
`default_nettype none

// Channel  Direction  Handshake               Payload
// in       input      i_in_valid / o_in_stall  t_in_item  (action, x, y, ink)
// out      output     o_out_valid / i_out_stall t_out_item (in_bounds, pixel_value)
// cfg      input      i_cfg_valid / o_cfg_ready display_profile (1 bit)
//
// Set and read run as an address and bounds check with the memory read,
// then the byte modify and, for set only, the write back through the single RAM port.
// Clear writes the ink fill byte to each used byte (6800 or 12000) in turn,
// then gives one result.
// Out-of-bounds and unused action codes go from the accept state straight to the result state.
// After reset a zeroing sweep over all STORE_BYTES bytes runs with the input
// stalled; config writes are taken at any time.
// A result waits in the output register under stall while the next item is
// accepted; the block holds an item at its final step until the slot frees.

module mono_framebuffer_pixel_store
    import mfb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_data,
    output logic           o_cfg_ready
);

    // Pixel store, MSB-first bytes
    logic [7:0] r_pixel_bytes [STORE_BYTES];
    logic [7:0] r_rd_data;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_last, n_last;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]       r_mask, n_mask;
    logic [7:0]       r_fill, n_fill;
    logic [1:0]       r_act, n_act;
    logic             r_ink, n_ink;
    t_out_item        r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic             r_profile;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_wa;
    logic [ADDR_W-1:0] mem_ra;
    logic [7:0]        mem_wd;

    // Geometry of the current profile
    logic [8:0] geo_w;
    logic [7:0] geo_h;
    logic [5:0] geo_stride;
    logic [CNT_W-1:0] geo_last;

    always_comb begin
        if (r_profile) begin
            geo_w      = WIDTH_P1;
            geo_h      = HEIGHT_P1;
            geo_stride = STRIDE_P1;
            geo_last   = LAST_P1;
        end else begin
            geo_w      = WIDTH_P0;
            geo_h      = HEIGHT_P0;
            geo_stride = STRIDE_P0;
            geo_last   = LAST_P0;
        end
    end

    // Bounds check and byte address of the incoming pixel
    logic [15:0] in_x;
    logic [15:0] in_y;
    logic        in_inside;
    logic [13:0] row_base;
    logic [15:0] byte_addr;
    logic        addr_ok;
    logic        is_pixel_op;
    logic        out_free;
    logic        cnt_last;

    assign in_x      = $unsigned(i_in_data.x_coord);
    assign in_y      = $unsigned(i_in_data.y_coord);
    assign in_inside = !in_x[15] && !in_y[15]
                       && (in_x < {7'd0, geo_w}) && (in_y < {8'd0, geo_h});
    assign row_base  = 14'(in_y[7:0]) * 14'(geo_stride);
    assign byte_addr = 16'(row_base) + 16'(in_x[15:3]);
    assign addr_ok   = 32'(byte_addr) < 32'(STORE_BYTES);
    assign is_pixel_op = (i_in_data.action == ACT_SET) || (i_in_data.action == ACT_READ);

    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_last = (r_state == ST_INIT) ? (r_cnt == LAST_INIT) : (r_cnt == r_last);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (cnt_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == ACT_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if (is_pixel_op && in_inside && addr_ok) begin
                        n_state = ST_RMW;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_CLEAR: begin
                if (cnt_last) n_state = ST_RESP;
            end
            ST_RMW: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and output slot
    always_comb begin
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_fill      = r_fill;
        n_act       = r_act;
        n_ink       = r_ink;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wa      = r_cnt[ADDR_W-1:0];
        mem_ra      = byte_addr[ADDR_W-1:0];
        mem_wd      = r_fill;
        unique case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
                mem_wd = 8'd0;
                n_cnt  = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_act  = i_in_data.action;
                    n_ink  = i_in_data.ink_black;
                    n_addr = byte_addr[ADDR_W-1:0];
                    n_mask = MASK_MSB >> in_x[2:0];
                    n_fill = i_in_data.ink_black ? FILL_ONE : 8'd0;
                    n_cnt  = '0;
                    n_last = geo_last;
                    n_res.in_bounds   = is_pixel_op && in_inside;
                    n_res.pixel_value = 1'b0;
                    mem_re = is_pixel_op && in_inside && addr_ok;
                end
            end
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                n_res.in_bounds   = 1'b1;
                n_res.pixel_value = 1'b0;
            end
            ST_RMW: begin
                if (out_free) begin
                    mem_wa = r_addr;
                    mem_wd = r_ink ? (r_rd_data | r_mask) : (r_rd_data & ~r_mask);
                    mem_we = (r_act == ACT_SET);
                    n_out.in_bounds   = 1'b1;
                    n_out.pixel_value = (r_act == ACT_READ) && ((r_rd_data & r_mask) != 8'd0);
                    n_out_valid = 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_profile   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_profile <= i_cfg_data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_addr <= n_addr;
        r_mask <= n_mask;
        r_fill <= n_fill;
        r_act  <= n_act;
        r_ink  <= n_ink;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // Single-port store, registered read; write and read never share a cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_pixel_bytes[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= r_pixel_bytes[mem_ra];
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire
